>>> src/assert_macros.svh
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define XMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("xmt assertion failed");
// Implication checked in the same cycle.
`define XMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xmt implication failed");
`else
`define XMT_ASSERT(lbl, prop)
`define XMT_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> src/xmt_pkg.sv
// Types, character constants and the result-list helper of the tokenizer.
package xmt_pkg;

  // Parser modes
  typedef enum logic [4:0] {
    M_SEEK, M_TYPE, M_NAME, M_ATTR_GAP, M_ATTR_NAME, M_VAL_GAP, M_VAL_BARE,
    M_VAL_SQ, M_VAL_DQ, M_TEXT, M_TEXT_LT, M_CLOSE_TAG, M_BANG, M_BANG_DASH,
    M_BANG_BRACKET, M_COMMENT, M_CDATA, M_NOTATION, M_DECL
  } mode_t;

  // Event codes
  typedef enum logic [3:0] {
    EV_NAME, EV_PREFIX, EV_OPEN, EV_CLOSE, EV_ATTR_NAME, EV_ATTR_VAL,
    EV_ATTR_DONE, EV_TEXT, EV_TEXT_KEPT, EV_TEXT_DROP, EV_COMMENT, EV_CDATA,
    EV_BODY_DONE, EV_END
  } event_t;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam int MAX_RES = 3;

  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
    logic [6:0] lvl;
    logic       ovf;
  } res_t;

  // Results of one byte, entry 0 first
  typedef struct packed {
    logic [1:0]      n;
    res_t [2:0]      r;
  } res_list_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // Append one result; full lists and muted body chars are dropped
  function automatic res_list_t push(input res_list_t l, input event_t ev,
                                     input logic [7:0] ch, input logic ovf,
                                     input logic [6:0] lvl, input logic mute);
    res_list_t o;
    o = l;
    if (l.n != 2'(MAX_RES) && !(mute && (ev == EV_COMMENT || ev == EV_CDATA))) begin
      o.r[l.n] = '{ev: ev, ch: ch, lvl: lvl, ovf: ovf};
      o.n = 2'(l.n + 2'd1);
    end
    return o;
  endfunction

endpackage

>>> src/xmt_core.sv
// Parser state and the single-pass decode of one byte into its results.
module xmt_core
  import xmt_pkg::*;
#(
  parameter int MAX_DEPTH  = 64,
  parameter int ENTITY_MAX = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic [7:0] ch,
  input  logic      eod,
  output res_list_t lst
);

  `include "assert_macros.svh"

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int LW = (ENTITY_MAX > 15) ? 5 : 4;
  localparam int IW = $clog2(ENTITY_MAX);

  mode_t           mode_r, mode_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [2:0]      la_r, la_nxt;
  logic [LW-1:0]   elen_r, elen_nxt;
  logic [7:0]      acc_r, acc_nxt;
  logic            on_r, on_nxt, bad_r, bad_nxt, skip_r, skip_nxt;
  logic [7:0]      ebuf_r [ENTITY_MAX];
  logic [7:0]      ebuf_nxt [ENTITY_MAX];

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_SEEK;
      depth_r <= '0;
      la_r    <= '0;
      elen_r  <= '0;
      acc_r   <= '0;
      on_r    <= 1'b0;
      bad_r   <= 1'b0;
      skip_r  <= 1'b0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      la_r    <= la_nxt;
      elen_r  <= elen_nxt;
      acc_r   <= acc_nxt;
      on_r    <= on_nxt;
      bad_r   <= bad_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // Entity name bytes, no reset
  always_ff @(posedge clk) begin
    if (adv) ebuf_r <= ebuf_nxt;
  end

  // Decode: up to three mode hops per byte
  always_comb begin
    logic       run, do_open, do_close, do_val, do_body, ovf;
    event_t     vev, bev;
    logic [7:0] closer;
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    la_nxt    = la_r;
    elen_nxt  = elen_r;
    acc_nxt   = acc_r;
    on_nxt    = on_r;
    bad_nxt   = bad_r;
    skip_nxt  = 1'b0;
    ebuf_nxt  = ebuf_r;
    lst       = '0;
    ovf       = 1'b0;
    run       = !skip_r;
    for (int p = 0; p < 3; p++) begin
      do_open  = 1'b0;
      do_close = 1'b0;
      do_val   = 1'b0;
      do_body  = 1'b0;
      vev      = EV_TEXT;
      bev      = EV_COMMENT;
      closer   = CH_DASH;
      if (run) begin
        run = 1'b0;
        unique case (mode_nxt)
          M_SEEK: if (ch == CH_LT) mode_nxt = M_TYPE;
          M_TYPE: begin
            if (ch == CH_SLASH) begin
              do_close = 1'b1;
              mode_nxt = M_CLOSE_TAG;
            end else if (ch == CH_BANG) mode_nxt = M_BANG;
            else if (ch == CH_QMARK) mode_nxt = M_DECL;
            else begin
              mode_nxt = M_NAME;
              run = 1'b1;
            end
          end
          M_NAME: begin
            if (ch == CH_GT) begin
              do_open = 1'b1;
              on_nxt = 1'b0;
              mode_nxt = M_TEXT;
            end else if (ch == CH_SLASH) begin
              do_open = 1'b1;
              do_close = 1'b1;
              skip_nxt = 1'b1;
              mode_nxt = M_SEEK;
            end else if (ch == CH_COLON) begin
              lst = push(lst, EV_PREFIX, CH_COLON, 1'b0, 7'(depth_nxt), eod);
            end else if (is_ws(ch)) begin
              do_open = 1'b1;
              mode_nxt = M_ATTR_GAP;
            end else begin
              lst = push(lst, EV_NAME, ch, 1'b0, 7'(depth_nxt), eod);
            end
          end
          M_ATTR_GAP: begin
            if (ch == CH_GT) begin
              on_nxt = 1'b0;
              mode_nxt = M_TEXT;
            end else if (ch == CH_SLASH || ch == CH_QMARK) begin
              do_close = 1'b1;
              skip_nxt = 1'b1;
              mode_nxt = M_SEEK;
            end else if (!is_ws(ch)) begin
              mode_nxt = M_ATTR_NAME;
              run = 1'b1;
            end
          end
          M_ATTR_NAME: begin
            if (ch == CH_EQ || is_ws(ch)) mode_nxt = M_VAL_GAP;
            else lst = push(lst, EV_ATTR_NAME, ch, 1'b0, 7'(depth_nxt), eod);
          end
          M_VAL_GAP: begin
            if (!(is_ws(ch) || ch == CH_EQ)) begin
              on_nxt = 1'b0;
              if (ch == CH_SQ) mode_nxt = M_VAL_SQ;
              else if (ch == CH_DQ) mode_nxt = M_VAL_DQ;
              else begin
                mode_nxt = M_VAL_BARE;
                run = 1'b1;
              end
            end
          end
          M_VAL_BARE, M_VAL_SQ, M_VAL_DQ: begin
            if ((mode_nxt == M_VAL_BARE && is_ws(ch)) ||
                (mode_nxt == M_VAL_SQ && ch == CH_SQ) ||
                (mode_nxt == M_VAL_DQ && ch == CH_DQ)) begin
              lst = push(lst, EV_ATTR_DONE, 8'h00, 1'b0, 7'(depth_nxt), eod);
              on_nxt = 1'b0;
              mode_nxt = M_ATTR_GAP;
            end else begin
              do_val = 1'b1;
              vev = EV_ATTR_VAL;
            end
          end
          M_TEXT: begin
            if (ch == CH_LT) begin
              on_nxt = 1'b0;
              mode_nxt = M_TEXT_LT;
            end else begin
              do_val = 1'b1;
              vev = EV_TEXT;
            end
          end
          M_TEXT_LT: begin
            if (ch == CH_SLASH) begin
              lst = push(lst, EV_TEXT_KEPT, 8'h00, 1'b0, 7'(depth_nxt), eod);
              do_close = 1'b1;
              mode_nxt = M_CLOSE_TAG;
            end else begin
              lst = push(lst, EV_TEXT_DROP, 8'h00, 1'b0, 7'(depth_nxt), eod);
              mode_nxt = M_TYPE;
              run = 1'b1;
            end
          end
          M_CLOSE_TAG, M_NOTATION, M_DECL: if (ch == CH_GT) mode_nxt = M_SEEK;
          M_BANG: begin
            if (ch == CH_DASH) mode_nxt = M_BANG_DASH;
            else if (ch == CH_LBRK) begin
              la_nxt = 3'd1;
              mode_nxt = M_BANG_BRACKET;
            end else begin
              mode_nxt = M_NOTATION;
              run = 1'b1;
            end
          end
          M_BANG_DASH: begin
            if (ch == CH_DASH) begin
              la_nxt = '0;
              mode_nxt = M_COMMENT;
            end else begin
              mode_nxt = M_NOTATION;
              run = 1'b1;
            end
          end
          M_BANG_BRACKET: begin
            la_nxt = 3'(la_nxt + 3'd1);
            if (la_nxt == 3'd7) begin
              la_nxt = '0;
              if (ch == CH_LBRK) mode_nxt = M_CDATA;
              else begin
                mode_nxt = M_NOTATION;
                run = 1'b1;
              end
            end
          end
          M_COMMENT: begin
            do_body = 1'b1;
            closer = CH_DASH;
            bev = EV_COMMENT;
          end
          M_CDATA: begin
            do_body = 1'b1;
            closer = CH_RBRK;
            bev = EV_CDATA;
          end
          default: mode_nxt = M_SEEK;
        endcase

        // Element open, then close (self-closing tags do both)
        if (do_open) begin
          ovf = (depth_nxt >= DW'(MAX_DEPTH));
          if (!ovf) depth_nxt = DW'(depth_nxt + 1'b1);
          lst = push(lst, EV_OPEN, 8'h00, ovf, 7'(depth_nxt), eod);
        end
        if (do_close) begin
          ovf = (depth_nxt == '0);
          if (!ovf) depth_nxt = DW'(depth_nxt - 1'b1);
          lst = push(lst, EV_CLOSE, 8'h00, ovf, 7'(depth_nxt), eod);
        end

        // Text or value byte with entity decoding
        if (do_val) begin
          if (!on_nxt) begin
            if (ch == CH_AMP) begin
              on_nxt = 1'b1;
              bad_nxt = 1'b0;
              elen_nxt = '0;
              acc_nxt = '0;
            end else begin
              lst = push(lst, vev, ch, 1'b0, 7'(depth_nxt), eod);
            end
          end else if (ch == CH_SEMI) begin
            on_nxt = 1'b0;
            if (!bad_nxt) begin
              if (elen_nxt != '0 && ebuf_nxt[0] == CH_HASH) begin
                if (elen_nxt >= LW'(2))
                  lst = push(lst, vev, acc_nxt, 1'b0, 7'(depth_nxt), eod);
              end else if (elen_nxt == LW'(3) && ebuf_nxt[0] == CH_A &&
                           ebuf_nxt[1] == CH_M && ebuf_nxt[2] == CH_P) begin
                lst = push(lst, vev, CH_AMP, 1'b0, 7'(depth_nxt), eod);
              end else if (elen_nxt == LW'(2) && ebuf_nxt[0] == CH_L &&
                           ebuf_nxt[1] == CH_T) begin
                lst = push(lst, vev, CH_LT, 1'b0, 7'(depth_nxt), eod);
              end else if (elen_nxt == LW'(2) && ebuf_nxt[0] == CH_G &&
                           ebuf_nxt[1] == CH_T) begin
                lst = push(lst, vev, CH_GT, 1'b0, 7'(depth_nxt), eod);
              end else if (elen_nxt == LW'(4) && ebuf_nxt[0] == CH_A &&
                           ebuf_nxt[1] == CH_P && ebuf_nxt[2] == CH_O &&
                           ebuf_nxt[3] == CH_S) begin
                lst = push(lst, vev, CH_SQ, 1'b0, 7'(depth_nxt), eod);
              end else if (elen_nxt == LW'(4) && ebuf_nxt[0] == CH_Q &&
                           ebuf_nxt[1] == CH_U && ebuf_nxt[2] == CH_O &&
                           ebuf_nxt[3] == CH_T) begin
                lst = push(lst, vev, CH_DQ, 1'b0, 7'(depth_nxt), eod);
              end
            end
          end else if (elen_nxt == '0 && ch == CH_HASH) begin
            ebuf_nxt[0] = CH_HASH;
            elen_nxt = LW'(1);
          end else if (elen_nxt != '0 && ebuf_nxt[0] == CH_HASH) begin
            if (ch >= CH_0 && ch <= CH_9) begin
              acc_nxt = 8'((acc_nxt << 3) + (acc_nxt << 1) + (ch - CH_0));
              if (elen_nxt < LW'(15)) elen_nxt = LW'(elen_nxt + 1'b1);
            end else begin
              bad_nxt = 1'b1;
            end
          end else if (elen_nxt < LW'(ENTITY_MAX)) begin
            ebuf_nxt[elen_nxt[IW-1:0]] = ch;
            elen_nxt = LW'(elen_nxt + 1'b1);
          end else begin
            bad_nxt = 1'b1;
          end
        end

        // Comment / CDATA body with held-back closer chars
        if (do_body) begin
          if (ch == closer) begin
            if (la_nxt < 3'd2) la_nxt = 3'(la_nxt + 3'd1);
            else lst = push(lst, bev, closer, 1'b0, 7'(depth_nxt), eod);
          end else if (ch == CH_GT && la_nxt == 3'd2) begin
            la_nxt = '0;
            lst = push(lst, EV_BODY_DONE, 8'h00, 1'b0, 7'(depth_nxt), eod);
            mode_nxt = M_SEEK;
          end else begin
            if (la_nxt >= 3'd1) lst = push(lst, bev, closer, 1'b0, 7'(depth_nxt), eod);
            if (la_nxt >= 3'd2) lst = push(lst, bev, closer, 1'b0, 7'(depth_nxt), eod);
            la_nxt = '0;
            lst = push(lst, bev, ch, 1'b0, 7'(depth_nxt), eod);
          end
        end
      end
    end

    // End of document: end beat always fits, then back to reset state
    if (eod) begin
      if (lst.n == 2'(MAX_RES)) lst.n = 2'(MAX_RES - 1);
      lst = push(lst, EV_END, 8'h00, 1'b0, 7'(depth_nxt), 1'b0);
      mode_nxt  = M_SEEK;
      depth_nxt = '0;
      la_nxt    = '0;
      elen_nxt  = '0;
      acc_nxt   = '0;
      on_nxt    = 1'b0;
      bad_nxt   = 1'b0;
      skip_nxt  = 1'b0;
    end
  end

  `XMT_ASSERT(a_depth_range, depth_r <= DW'(MAX_DEPTH))
  `XMT_ASSERT_IMP(a_body_hold, (mode_r == M_COMMENT || mode_r == M_CDATA), la_r <= 3'd2)
  `XMT_ASSERT(a_eod_clears, (adv && eod) |=> (mode_r == M_SEEK && depth_r == '0 && !skip_r))

endmodule

>>> src/xmt_obuf.sv
// Result register: holds the beats of one byte and hands them out in order.
module xmt_obuf
  import xmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_list_t  lst,
  output logic       free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_event_res,
  output logic [7:0] out_out_char,
  output logic [6:0] out_level,
  output logic       out_depth_overflow,
  output logic       out_last_of_run
);

  `include "assert_macros.svh"

  res_t       buf_r [MAX_RES];
  logic [1:0] cnt_r, idx_r;
  logic       last, take;

  assign out_valid = (cnt_r != '0);
  assign last      = (idx_r == 2'(cnt_r - 2'd1));
  assign take      = out_valid && !out_stall;
  assign free      = !out_valid || (take && last);

  // Beat payload
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) buf_r[i] <= lst.r[i];
    end
  end

  // Fill count and read pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= lst.n;
      idx_r <= '0;
    end else if (take) begin
      if (last) cnt_r <= '0;
      else idx_r <= 2'(idx_r + 2'd1);
    end
  end

  assign out_event_res      = buf_r[idx_r].ev;
  assign out_out_char       = buf_r[idx_r].ch;
  assign out_level          = buf_r[idx_r].lvl;
  assign out_depth_overflow = buf_r[idx_r].ovf;
  assign out_last_of_run    = last;

  `XMT_ASSERT(a_cnt_range, cnt_r <= 2'(MAX_RES))
  `XMT_ASSERT_IMP(a_idx_in_range, out_valid, idx_r < cnt_r)
  `XMT_ASSERT_IMP(a_load_when_free, load, free)

endmodule

>>> src/xml_markup_tokenizer_unit.sv
// Top level of the streaming XML tokenizer: input register, decoder, result register.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_stall   | ch, end_of_doc
//  out_    | output    | out_valid/out_stall | event_res, out_char, level, ovf, last_of_run
//
// One byte is decoded per cycle while in_stall is low; a byte yields zero to three beats,
// drained one a cycle from the result register while out_ does not stall.
// An in_ beat passes through the input register and the decoder into the result register before its first out_ beat.
// rst_n is synchronous: parser returns to tag search at depth zero.
// A stall on out_ backs up through the result register into in_stall.
module xml_markup_tokenizer_unit
  import xmt_pkg::*;
#(
  parameter int MAX_DEPTH  = 64,
  parameter int ENTITY_MAX = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_doc,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_event_res,
  output logic [7:0] out_out_char,
  output logic [6:0] out_level,
  output logic       out_depth_overflow,
  output logic       out_last_of_run
);

  logic       hold_vld_r;
  logic [7:0] ch_r;
  logic       eod_r;
  logic       free, adv;
  res_list_t  lst;

  assign adv      = hold_vld_r && free;
  assign in_stall = hold_vld_r && !free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (!in_stall) begin
      hold_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_r  <= in_ch;
      eod_r <= in_end_of_doc;
    end
  end

  xmt_core #(
    .MAX_DEPTH  (MAX_DEPTH),
    .ENTITY_MAX (ENTITY_MAX)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ch    (ch_r),
    .eod   (eod_r),
    .lst   (lst)
  );

  xmt_obuf u_obuf (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (adv),
    .lst                (lst),
    .free               (free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_out_char       (out_out_char),
    .out_level          (out_level),
    .out_depth_overflow (out_depth_overflow),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
